>>> sv/lsm_pkg.sv
package lsm_pkg;

    // ASCII bytes that separate words, and the letter bounds and offset for case folding
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_NL    = 8'h0A;
    localparam logic [7:0] ASCII_UC_A  = 8'h41;
    localparam logic [7:0] ASCII_UC_Z  = 8'h5A;
    localparam logic [7:0] ASCII_CASE  = 8'h20;

    // Pattern storage is fixed by the register map: two 64-bit words
    localparam int PAT_BYTES = 16;

    // Register indexes on the configuration port (byte address = 8 * index)
    typedef enum logic [2:0] {
        REG_PAT_LO   = 3'd0,
        REG_PAT_HI   = 3'd1,
        REG_PAT_LEN  = 3'd2,
        REG_IGN_CASE = 3'd3,
        REG_WHOLE_WD = 3'd4
    } t_reg_idx;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern;
        logic [4:0]             pattern_length;
        logic                   ignore_case;
        logic                   whole_word;
    } t_cfg;

    // Verdict of the window compare for one item
    typedef struct packed {
        logic hit;
        logic before_ok;
    } t_match;

    // Fold an upper-case ASCII letter to lower case when enabled
    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && (c >= ASCII_UC_A) && (c <= ASCII_UC_Z)) begin
            r = c + ASCII_CASE;
        end
        return r;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == ASCII_SPACE) || (c == ASCII_NL);
    endfunction

endpackage

>>> sv/lsm_cfg.sv
module lsm_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output lsm_pkg::t_cfg o_cfg
);

    logic [63:0] r_pat_lo;
    logic [63:0] r_pat_hi;
    logic [4:0]  r_len;
    logic        r_ign_case;
    logic        r_whole_wd;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo   <= '0;
            r_pat_hi   <= '0;
            r_len      <= 5'd1;
            r_ign_case <= 1'b0;
            r_whole_wd <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[5:3])
                lsm_pkg::REG_PAT_LO:   r_pat_lo   <= pwdata;
                lsm_pkg::REG_PAT_HI:   r_pat_hi   <= pwdata;
                lsm_pkg::REG_PAT_LEN:  r_len      <= pwdata[4:0];
                lsm_pkg::REG_IGN_CASE: r_ign_case <= pwdata[0];
                lsm_pkg::REG_WHOLE_WD: r_whole_wd <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (paddr[5:3])
            lsm_pkg::REG_PAT_LO:   prdata = r_pat_lo;
            lsm_pkg::REG_PAT_HI:   prdata = r_pat_hi;
            lsm_pkg::REG_PAT_LEN:  prdata = 64'(r_len);
            lsm_pkg::REG_IGN_CASE: prdata = 64'(r_ign_case);
            lsm_pkg::REG_WHOLE_WD: prdata = 64'(r_whole_wd);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.pattern        = {r_pat_hi, r_pat_lo};
    assign o_cfg.pattern_length = r_len;
    assign o_cfg.ignore_case    = r_ign_case;
    assign o_cfg.whole_word     = r_whole_wd;

endmodule

>>> sv/lsm_match.sv
module lsm_match #(
    parameter int MAX_PATTERN = 16
) (
    input  logic [MAX_PATTERN:0][7:0]                i_window,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]         i_len,
    input  logic [$clog2(MAX_PATTERN+2)-1:0]         i_bytes,
    input  lsm_pkg::t_cfg                            i_cfg,
    output lsm_pkg::t_match                          o_match
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int BW = $clog2(MAX_PATTERN + 2);

    logic [LW-1:0] w_idx;
    logic          w_hit;

    // Compare the newest len bytes against the pattern, oldest byte first
    always_comb begin
        w_hit = (i_bytes >= BW'(i_len));
        w_idx = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k < int'(i_len)) begin
                w_idx = LW'(int'(i_len) - 1 - k);
                if (lsm_pkg::fold(i_window[w_idx], i_cfg.ignore_case) !=
                    lsm_pkg::fold(i_cfg.pattern[8*k +: 8], i_cfg.ignore_case)) begin
                    w_hit = 1'b0;
                end
            end
        end
    end

    // Occurrence starts the line or follows a separator
    assign o_match.hit       = w_hit;
    assign o_match.before_ok = (i_bytes == BW'(i_len)) || lsm_pkg::is_sep(i_window[i_len]);

endmodule

>>> sv/lsm_sat_counter.sv
module lsm_sat_counter #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_inc,
    output logic [WIDTH-1:0] o_count,
    output logic [WIDTH-1:0] o_next
);

    logic [WIDTH-1:0] r_count;
    logic [WIDTH-1:0] w_base;

    // Clear first, then count up and hold at the top
    always_comb begin
        w_base = i_clear ? '0 : r_count;
        o_next = w_base;
        if (i_inc && (w_base != '1)) begin
            o_next = w_base + WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= o_next;
        end
    end

    assign o_count = r_count;

endmodule

>>> sv/line_substring_matcher.sv
// A processed line-ending byte loads the result register from the input register.
// Throughput: one text byte per cycle; the window compare and the next line state are
// combinational between the input register and the result register.
// A line result waiting on m_axis_tready stalls only the next line-ending byte.
// Reset (synchronous, active low) clears line state, counters, valids and
// configuration (pattern length 1); no clearing pass is needed.
module line_substring_matcher #(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // line_last
    input  logic        s_axis_tuser,   // [0] file_first
    // result item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] line_number, [63:32] file_match_count,
                                        // [95:64] total_match_count
    output logic        m_axis_tuser,   // [0] line_matched
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int WINDOW = MAX_PATTERN + 1;
    localparam int LW     = $clog2(MAX_PATTERN + 1);
    localparam int BW     = $clog2(MAX_PATTERN + 2);

    lsm_pkg::t_cfg   w_cfg;
    lsm_pkg::t_match w_match;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_in_first;

    // line state
    logic [MAX_PATTERN:0][7:0] r_hist;
    logic [MAX_PATTERN:0][7:0] n_hist;
    logic [BW-1:0]             r_bil;
    logic [BW-1:0]             n_bil;
    logic                      r_occ;
    logic                      n_occ;
    logic                      r_await;
    logic                      n_await;
    logic                      r_found;
    logic                      n_found;

    // result register
    logic        r_out_vld;
    logic        r_out_matched;
    logic [31:0] r_out_line;
    logic [31:0] r_out_file;
    logic [31:0] r_out_total;

    logic          w_proc;
    logic [LW-1:0] w_len;
    logic          w_found;
    logic [BW-1:0] w_base_bil;
    logic          w_base_occ;
    logic          w_base_await;
    logic          w_base_found;

    logic [COUNT_WIDTH-1:0] w_line_cnt;
    logic [COUNT_WIDTH-1:0] w_line_nxt;
    logic [COUNT_WIDTH-1:0] w_file_cnt;
    logic [COUNT_WIDTH-1:0] w_file_nxt;
    logic [COUNT_WIDTH-1:0] w_total_cnt;
    logic [COUNT_WIDTH-1:0] w_total_nxt;

    lsm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance the held item unless it ends a line and the result slot is blocked
    assign w_proc        = r_in_vld && (!r_in_last || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_last  <= s_axis_tlast;
            r_in_first <= s_axis_tuser;
        end
    end

    // Clamp the pattern length into 1..MAX_PATTERN
    always_comb begin
        if (w_cfg.pattern_length == 5'd0) begin
            w_len = LW'(1);
        end else if (w_cfg.pattern_length > 5'(MAX_PATTERN)) begin
            w_len = LW'(MAX_PATTERN);
        end else begin
            w_len = LW'(w_cfg.pattern_length);
        end
    end

    // Drop the unfinished line on a new file, shift in the byte
    always_comb begin
        w_base_bil   = r_in_first ? '0 : r_bil;
        w_base_occ   = r_in_first ? 1'b0 : r_occ;
        w_base_await = r_in_first ? 1'b0 : r_await;
        w_base_found = r_in_first ? 1'b0 : r_found;
        n_hist       = {r_hist[MAX_PATTERN-1:0], r_in_byte};
        n_bil        = (w_base_bil == BW'(WINDOW)) ? w_base_bil : w_base_bil + BW'(1);
    end

    lsm_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_window (n_hist),
        .i_len    (w_len),
        .i_bytes  (n_bil),
        .i_cfg    (w_cfg),
        .o_match  (w_match)
    );

    // Apply the match rule; only the leftmost occurrence counts in whole-word mode
    always_comb begin
        w_found = w_base_found || (w_base_await && lsm_pkg::is_sep(r_in_byte));
        n_occ   = w_base_occ;
        n_await = 1'b0;
        if (w_match.hit) begin
            if (!w_cfg.whole_word) begin
                w_found = 1'b1;
            end else if (!w_base_occ) begin
                n_occ = 1'b1;
                if (w_match.before_ok) begin
                    if (r_in_last) begin
                        w_found = 1'b1;
                    end else begin
                        n_await = 1'b1;
                    end
                end
            end
        end
        n_found = w_found;
    end

    // Hold line state between bytes, clear it at line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bil   <= '0;
            r_occ   <= 1'b0;
            r_await <= 1'b0;
            r_found <= 1'b0;
        end else if (w_proc) begin
            if (r_in_last) begin
                r_bil   <= '0;
                r_occ   <= 1'b0;
                r_await <= 1'b0;
                r_found <= 1'b0;
            end else begin
                r_bil   <= n_bil;
                r_occ   <= n_occ;
                r_await <= n_await;
                r_found <= n_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_hist <= n_hist;
        end
    end

    // Line, per-file and overall counters
    lsm_sat_counter #(.WIDTH (COUNT_WIDTH)) u_line_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_proc && r_in_first),
        .i_inc   (w_proc && r_in_last),
        .o_count (w_line_cnt),
        .o_next  (w_line_nxt)
    );

    lsm_sat_counter #(.WIDTH (COUNT_WIDTH)) u_file_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_proc && r_in_first),
        .i_inc   (w_proc && r_in_last && w_found),
        .o_count (w_file_cnt),
        .o_next  (w_file_nxt)
    );

    lsm_sat_counter #(.WIDTH (COUNT_WIDTH)) u_total_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (1'b0),
        .i_inc   (w_proc && r_in_last && w_found),
        .o_count (w_total_cnt),
        .o_next  (w_total_nxt)
    );

    // Load the result register at line end, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_last) begin
            r_out_matched <= w_found;
            r_out_line    <= 32'(w_line_nxt);
            r_out_file    <= 32'(w_file_nxt);
            r_out_total   <= 32'(w_total_nxt);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_matched;
    assign m_axis_tdata  = {r_out_total, r_out_file, r_out_line};

    // A result appears only after a line-ending item was processed
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_proc && r_in_last))
        else $error("result without a line-ending item");

    // A line end never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |-> !(w_proc && r_in_last))
        else $error("line result overwritten while stalled");

    // Matches in one file never exceed matches overall
    a_file_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_file_cnt <= w_total_cnt)
        else $error("file match count above total");

    // Line byte count stays within the window and lines stay consistent
    a_bil_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bil <= BW'(WINDOW)) && (!r_await || r_occ))
        else $error("line state out of range");

    // The line counter moves only when an item is processed
    a_line_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_proc) |-> $stable(w_line_cnt))
        else $error("line counter moved without an item");

endmodule

>>> sim/line_substring_matcher_checker.sv
`timescale 1ns / 100ps

module line_substring_matcher_checker #(
    parameter int MAX_PATTERN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // text side
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] text_byte
    input  logic        i_s_tlast,    // line_last
    input  logic        i_s_tuser,    // [0] file_first
    // line result side
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,    // [31:0] line_number, [63:32] file_match_count,
                                      // [95:64] total_match_count
    input  logic        i_m_tuser,    // [0] line_matched
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [5:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output int          o_open_lines,
    output int          o_fail_count
);

    localparam int WINDOW = MAX_PATTERN + 1;

    typedef struct packed {
        logic        matched;
        logic [31:0] line_no;
        logic [31:0] file_hits;
        logic [31:0] total_hits;
    } t_line_report;

    // search setup as last written over the register port
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len_code;
    logic        fold_case;
    logic        word_mode;

    // state of the line in progress and the counters
    logic [7:0]  window_bytes [WINDOW];
    int          line_fill;
    logic        first_occ_taken;
    logic        follow_pending;
    logic        line_hit;
    logic [31:0] line_no;
    logic [31:0] file_hits;
    logic [31:0] total_hits;

    t_line_report expected_lines [$];
    t_line_report oldest_line;
    int           fail_total;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (fold_case && (c >= lsm_pkg::ASCII_UC_A) && (c <= lsm_pkg::ASCII_UC_Z)) begin
            return c + lsm_pkg::ASCII_CASE;
        end
        return c;
    endfunction

    function automatic logic [7:0] pattern_byte(input int k);
        if (k < 8) begin
            return pat_lo[8*k +: 8];
        end
        return pat_hi[8*(k-8) +: 8];
    endfunction

    function automatic logic is_word_gap(input logic [7:0] c);
        return (c == lsm_pkg::ASCII_SPACE) || (c == lsm_pkg::ASCII_NL);
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic clear_line();
        for (int k = 0; k < WINDOW; k++) begin
            window_bytes[k] = 8'h00;
        end
        line_fill       = 0;
        first_occ_taken = 1'b0;
        follow_pending  = 1'b0;
        line_hit        = 1'b0;
    endtask

    // Advance the line state by one text byte; queue a report on a line end
    task automatic judge_text_byte(input logic [7:0] b, input logic last, input logic first);
        int           eff_len;
        int           k;
        logic         hit;
        logic         lead_ok;
        t_line_report rep;
        eff_len = (pat_len_code == 5'd0) ? 1 :
                  (pat_len_code > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_code);

        // a new file drops the partial line and restarts the file counters
        if (first) begin
            clear_line();
            line_no   = 32'd0;
            file_hits = 32'd0;
        end

        // the byte after a word-mode candidate decides it
        if (follow_pending) begin
            follow_pending = 1'b0;
            if (is_word_gap(b)) begin
                line_hit = 1'b1;
            end
        end

        for (k = WINDOW - 1; k > 0; k--) begin
            window_bytes[k] = window_bytes[k-1];
        end
        window_bytes[0] = b;
        if (line_fill < WINDOW) begin
            line_fill++;
        end

        hit = (line_fill >= eff_len);
        for (k = 0; hit && (k < eff_len); k++) begin
            if (fold_byte(window_bytes[eff_len-1-k]) != fold_byte(pattern_byte(k))) begin
                hit = 1'b0;
            end
        end

        if (hit) begin
            if (!word_mode) begin
                line_hit = 1'b1;
            end else if (!first_occ_taken) begin
                // only the leftmost occurrence is ever tested
                lead_ok = (line_fill == eff_len) || is_word_gap(window_bytes[eff_len]);
                first_occ_taken = 1'b1;
                if (lead_ok) begin
                    if (last) begin
                        line_hit = 1'b1;
                    end else begin
                        follow_pending = 1'b1;
                    end
                end
            end
        end

        if (last) begin
            line_no = bump(line_no);
            if (line_hit) begin
                file_hits  = bump(file_hits);
                total_hits = bump(total_hits);
            end
            rep.matched    = line_hit;
            rep.line_no    = line_no;
            rep.file_hits  = file_hits;
            rep.total_hits = total_hits;
            expected_lines.push_back(rep);
            clear_line();
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d (0x%h) actual %0d (0x%h)",
                     $time, field, want, want, got, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_lo       = 64'd0;
            pat_hi       = 64'd0;
            pat_len_code = 5'd1;
            fold_case    = 1'b0;
            word_mode    = 1'b0;
            clear_line();
            line_no      = 32'd0;
            file_hits    = 32'd0;
            total_hits   = 32'd0;
            expected_lines.delete();
            fail_total   = 0;
        end else begin
            // compare a finished line against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (expected_lines.size() == 0) begin
                    fail_total++;
                    $display("%0t: line result with none expected, actual tuser=%0b tdata=0x%h",
                             $time, i_m_tuser, i_m_tdata);
                end else begin
                    oldest_line = expected_lines.pop_front();
                    check_field("line_matched", {31'd0, oldest_line.matched},
                                {31'd0, i_m_tuser});
                    check_field("line_number", oldest_line.line_no, i_m_tdata[31:0]);
                    check_field("file_match_count", oldest_line.file_hits,
                                i_m_tdata[63:32]);
                    check_field("total_match_count", oldest_line.total_hits,
                                i_m_tdata[95:64]);
                end
            end

            // track register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (lsm_pkg::t_reg_idx'(i_paddr[5:3]))
                    lsm_pkg::REG_PAT_LO:   pat_lo       = i_pwdata;
                    lsm_pkg::REG_PAT_HI:   pat_hi       = i_pwdata;
                    lsm_pkg::REG_PAT_LEN:  pat_len_code = i_pwdata[4:0];
                    lsm_pkg::REG_IGN_CASE: fold_case    = i_pwdata[0];
                    lsm_pkg::REG_WHOLE_WD: word_mode    = i_pwdata[0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                judge_text_byte(i_s_tdata, i_s_tlast, i_s_tuser);
            end
        end
        o_open_lines <= expected_lines.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> sim/line_substring_matcher_tb.sv
`timescale 1ns / 100ps

module line_substring_matcher_tb;

    localparam int MAX_PATTERN = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 132;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int          open_lines;
    int          fail_count;
    int          cycle_count;
    int          sent_items;
    logic        calm;

    // copy of the current pattern, used to plant occurrences in the text
    logic [63:0] gen_lo;
    logic [63:0] gen_hi;
    int          gen_len;
    logic [7:0]  line_bytes [$];

    line_substring_matcher #(
        .MAX_PATTERN(MAX_PATTERN),
        .COUNT_WIDTH(32)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    line_substring_matcher_checker #(
        .MAX_PATTERN(MAX_PATTERN)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_open_lines(open_lines),
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Mostly short gaps, a few long ones, none in calm phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || (r < 55)) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 13))
            0:       return "a";
            1:       return "b";
            2:       return "A";
            3:       return "B";
            4:       return "z";
            5:       return "Z";
            6:       return "@";
            7:       return "[";
            8:       return lsm_pkg::ASCII_SPACE;
            9:       return lsm_pkg::ASCII_NL;
            10:      return 8'h00;
            11:      return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side: stall at random
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    end

    // Offer one text item and hold it until accepted
    task automatic push_text_byte(input logic [7:0] b, input logic last, input logic first);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    task automatic send_text_line(input string s, input logic first);
        for (int k = 0; k < s.len(); k++) begin
            push_text_byte(s[k], k == s.len() - 1, first && (k == 0));
        end
    endtask

    // Stop sending and wait for every predicted line result
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (open_lines != 0) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        drain_results();
        // let a partial line in the pipeline settle before touching registers
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input lsm_pkg::t_reg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_search_setup(input logic [63:0] lo, input logic [63:0] hi,
                                     input logic [4:0] len_code, input logic ign,
                                     input logic word);
        wait_idle();
        write_reg(lsm_pkg::REG_PAT_LO, lo);
        write_reg(lsm_pkg::REG_PAT_HI, hi);
        write_reg(lsm_pkg::REG_PAT_LEN, {59'd0, len_code});
        write_reg(lsm_pkg::REG_IGN_CASE, {63'd0, ign});
        write_reg(lsm_pkg::REG_WHOLE_WD, {63'd0, word});
        gen_lo  = lo;
        gen_hi  = hi;
        gen_len = (len_code == 5'd0) ? 1 :
                  (len_code > MAX_PATTERN) ? MAX_PATTERN : int'(len_code);
    endtask

    // Build a line from planted occurrences, separators and noise, then send it
    task automatic send_random_line();
        int         target;
        int         r;
        int         k;
        logic [7:0] c;
        logic       noise_line;
        logic       new_file;
        target     = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 14);
        noise_line = ($urandom_range(0, 9) == 0);
        new_file   = ($urandom_range(0, 11) == 0);
        line_bytes.delete();
        while (line_bytes.size() < target) begin
            r = $urandom_range(0, 99);
            if (!noise_line && (r < 40)) begin
                for (k = 0; k < gen_len; k++) begin
                    c = (k < 8) ? gen_lo[8*k +: 8] : gen_hi[8*(k-8) +: 8];
                    // flip the case of some letters
                    if (($urandom_range(0, 2) == 0) &&
                        ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z")) begin
                        c = c ^ 8'h20;
                    end
                    line_bytes.push_back(c);
                end
                // spoil a few near misses
                if ($urandom_range(0, 7) == 0) begin
                    line_bytes[line_bytes.size() - 1] = 8'($urandom_range(0, 255));
                end
            end else if (r < 65) begin
                line_bytes.push_back(($urandom_range(0, 2) == 0) ? lsm_pkg::ASCII_NL
                                                                 : lsm_pkg::ASCII_SPACE);
            end else begin
                line_bytes.push_back(pick_text_byte());
            end
        end
        for (k = 0; k < line_bytes.size(); k++) begin
            push_text_byte(line_bytes[k], k == line_bytes.size() - 1,
                           ((k == 0) && new_file) || ($urandom_range(0, 99) == 0));
        end
    endtask

    initial begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len_code;
        logic        ign;
        logic        word;
        int          phase_start;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 6'd0;
        pwdata        = 64'd0;
        calm          = 1'b0;
        sent_items    = 0;
        gen_lo        = 64'd0;
        gen_hi        = 64'd0;
        gen_len       = 1;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a zero text byte matches the zero pattern left by reset
        push_text_byte(8'h00, 1'b1, 1'b0);
        push_text_byte(8'hFF, 1'b1, 1'b1);

        // word mode with case folding, pattern "CaT"
        load_search_setup(64'h0000_0000_0054_6143, '1, 5'd3, 1'b1, 1'b1);
        send_text_line("cAt", 1'b1);
        // leftmost occurrence fails, the later one is never tested
        send_text_line("cats cat", 1'b0);
        send_text_line("cat ", 1'b0);
        // new file in the middle of a line drops the partial line
        push_text_byte("c", 1'b0, 1'b0);
        push_text_byte("a", 1'b0, 1'b0);
        send_text_line("cat", 1'b1);

        // length code zero behaves as one
        load_search_setup(64'h0000_0000_0000_0043, 64'd0, 5'd0, 1'b0, 1'b0);
        push_text_byte("C", 1'b1, 1'b0);

        // random phases, each under its own search setup
        for (int phase = 0; phase < PHASES; phase++) begin
            for (int k = 0; k < 8; k++) begin
                lo[8*k +: 8] = pick_text_byte();
                hi[8*k +: 8] = pick_text_byte();
            end
            if ($urandom_range(0, 3) == 0) begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            case (phase)
                0:       len_code = 5'd1;
                1:       len_code = 5'd16;
                2:       len_code = 5'd0;
                3:       len_code = 5'd31;
                4: begin
                    len_code = 5'd16;
                    lo       = '0;
                    hi       = '0;
                end
                5: begin
                    len_code = 5'd9;
                    lo       = '1;
                    hi       = '1;
                end
                default: len_code = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                                                : 5'($urandom_range(1, 16));
            endcase
            if (phase < 4) begin
                ign  = (phase & 1) != 0;
                word = (phase & 2) != 0;
            end else begin
                ign  = 1'($urandom_range(0, 1));
                word = 1'($urandom_range(0, 1));
            end
            load_search_setup(lo, hi, len_code, ign, word);
            calm        = ((phase % 4) == 3);
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) begin
                send_random_line();
                if ($urandom_range(0, 39) == 0) begin
                    drain_results();
                end
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
sv/lsm_pkg.sv
sv/lsm_cfg.sv
sv/lsm_match.sv
sv/lsm_sat_counter.sv
sv/line_substring_matcher.sv
sim/line_substring_matcher_checker.sv
sim/line_substring_matcher_tb.sv
